// ===== rtl/gtpg_pkg.sv =====
// Types, constants and register codes for the gradient test pattern generator.
// No dependencies; imported by gtpg_cfg, the top module and the checker.
`default_nettype none

package gtpg_pkg;

  localparam int unsigned CoordW    = 12;             // pixel_row / pixel_col
  localparam int unsigned DimW      = 13;             // image_rows / image_cols
  localparam logic [12:0] MaxDim    = 13'd4096;       // dimension saturation
  localparam int unsigned LevelW    = 8;              // channel level
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 13;

  // diagonal ramp: 65025*(r^2+c^2) / ((R-1)^2+(C-1)^2), then isqrt
  localparam int unsigned SqSumW    = 25;
  localparam int unsigned DenW      = 25;
  localparam int unsigned DiagNumW  = 42;
  localparam int unsigned DiagQW    = 16;
  localparam logic [15:0] FullScaleSq = 16'd65025;
  localparam int unsigned SqrtBits  = 8;

  // linear ramps: 255*x / dim
  localparam int unsigned RampNumW  = 20;
  localparam int unsigned RampQW    = 8;
  localparam logic [7:0]  FullScale = 8'd255;

  // register stages ahead of the output register
  localparam int unsigned FrontStg  = 3;
  localparam int unsigned PipeStg   = FrontStg + DiagQW + SqrtBits;
  localparam int unsigned RampDly   = DiagQW + SqrtBits - RampQW;

  typedef enum logic [2:0] {
    CfgPattern = 3'd0,
    CfgChanSel = 3'd1,
    CfgFixed   = 3'd2,
    CfgRows    = 3'd3,
    CfgCols    = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    PatColRamp    = 3'd0,
    PatRowRamp    = 3'd1,
    PatDiag       = 3'd2,
    PatColRowPlane = 3'd3,
    PatTwoColRamp = 3'd4
  } pattern_e;

  typedef enum logic [1:0] {
    SelBlue  = 2'd0,
    SelGreen = 2'd1,
    SelRed   = 2'd2,
    SelAll   = 2'd3
  } chan_sel_e;

  typedef struct packed {
    logic [CoordW-1:0] pixel_row;
    logic [CoordW-1:0] pixel_col;
  } pix_in_t;

  typedef struct packed {
    logic [LevelW-1:0] blue_out;
    logic [LevelW-1:0] green_out;
    logic [LevelW-1:0] red_out;
    logic              coord_error;
  } pix_out_t;

  // register view handed from the config block to the datapath
  typedef struct packed {
    logic [2:0]        pattern;
    logic [1:0]        channel_select;
    logic [LevelW-1:0] fixed_value;
    logic [DimW-1:0]   rows;        // saturated to MaxDim
    logic [DimW-1:0]   cols;        // saturated to MaxDim
    logic [DenW-1:0]   den;         // (rows-1)^2 + (cols-1)^2
    logic              den_zero;
  } cfg_t;

endpackage

`default_nettype wire

// ===== rtl/gtpg_cfg.sv =====
// Configuration registers plus the derived diagonal denominator.
// Depends on gtpg_pkg.
`default_nettype none

module gtpg_cfg (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         cfg_valid_i,
  input  wire logic [gtpg_pkg::CfgIdxW-1:0] cfg_index_i,
  input  wire logic [gtpg_pkg::CfgDataW-1:0] cfg_data_i,
  output wire gtpg_pkg::cfg_t               cfg_o
);
  import gtpg_pkg::*;

  logic [2:0]        pattern_q;
  logic [1:0]        chan_sel_q;
  logic [LevelW-1:0] fixed_q;
  logic [DimW-1:0]   rows_raw_q, cols_raw_q;
  logic [DimW-1:0]   rows_sat, cols_sat;
  logic [CoordW-1:0] dr, dc;
  logic [2*CoordW-1:0] dr_sq_q, dc_sq_q;
  logic [DenW-1:0]   den_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pattern_q  <= 3'(PatColRamp);
      chan_sel_q <= 2'(SelAll);
      fixed_q    <= '0;
      rows_raw_q <= 13'd350;
      cols_raw_q <= 13'd350;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CfgPattern: pattern_q  <= cfg_data_i[2:0];
        CfgChanSel: chan_sel_q <= cfg_data_i[1:0];
        CfgFixed:   fixed_q    <= cfg_data_i[LevelW-1:0];
        CfgRows:    rows_raw_q <= cfg_data_i[DimW-1:0];
        CfgCols:    cols_raw_q <= cfg_data_i[DimW-1:0];
        default: ;
      endcase
    end
  end

  assign rows_sat = (rows_raw_q > MaxDim) ? MaxDim : rows_raw_q;
  assign cols_sat = (cols_raw_q > MaxDim) ? MaxDim : cols_raw_q;
  // 4096-1 wraps correctly in 12 bits; zero size never reaches the ramp
  assign dr = rows_sat[CoordW-1:0] - 12'd1;
  assign dc = cols_sat[CoordW-1:0] - 12'd1;

  // den_q settles after dr_sq_q; user must keep block idle; unenforced
  always_ff @(posedge clk_i) begin
    dr_sq_q <= (2*CoordW)'(dr) * (2*CoordW)'(dr);
    dc_sq_q <= (2*CoordW)'(dc) * (2*CoordW)'(dc);
    den_q   <= DenW'(dr_sq_q) + DenW'(dc_sq_q);
  end

  assign cfg_o.pattern        = pattern_q;
  assign cfg_o.channel_select = chan_sel_q;
  assign cfg_o.fixed_value    = fixed_q;
  assign cfg_o.rows           = rows_sat;
  assign cfg_o.cols           = cols_sat;
  assign cfg_o.den            = den_q;
  assign cfg_o.den_zero       = (den_q == '0);

endmodule

`default_nettype wire

// ===== rtl/gtpg_div_step.sv =====
// One registered restoring-division step: resolves quotient bit BIT.
// Depends on gtpg_pkg only by convention; fully parameterized.
`default_nettype none

module gtpg_div_step #(
  parameter int unsigned NW  = 20,
  parameter int unsigned DW  = 13,
  parameter int unsigned QW  = 8,
  parameter int unsigned BIT = 0
) (
  input  wire logic          clk_i,
  input  wire logic          en_i,
  input  wire logic [NW-1:0] rem_i,
  input  wire logic [DW-1:0] den_i,
  input  wire logic [QW-1:0] q_i,
  output logic      [NW-1:0] rem_o,
  output logic      [QW-1:0] q_o
);

  logic [NW-1:0] dsh;
  logic          take;

  assign dsh  = {{(NW-DW){1'b0}}, den_i} << BIT;
  assign take = (rem_i >= dsh);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_o <= take ? (rem_i - dsh) : rem_i;
      q_o   <= take ? (q_i | (QW'(1) << BIT)) : q_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtpg_sqrt_step.sv =====
// One registered integer square root step on a 16-bit radicand.
// Tracks the running square so no multiplier is needed. No dependencies.
`default_nettype none

module gtpg_sqrt_step #(
  parameter int unsigned BIT = 0
) (
  input  wire logic        clk_i,
  input  wire logic        en_i,
  input  wire logic [15:0] v_i,
  input  wire logic [7:0]  res_i,
  input  wire logic [15:0] sq_i,
  output logic      [15:0] v_o,
  output logic      [7:0]  res_o,
  output logic      [15:0] sq_o
);

  logic [16:0] cand;

  // (res + 2^b)^2 = res^2 + res*2^(b+1) + 2^(2b)
  assign cand = {1'b0, sq_i} + (17'(res_i) << (BIT + 1)) + (17'(1) << (2 * BIT));

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      v_o <= v_i;
      if (cand <= {1'b0, v_i}) begin
        res_o <= res_i | (8'(1) << BIT);
        sq_o  <= cand[15:0];
      end else begin
        res_o <= res_i;
        sq_o  <= sq_i;
      end
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gradient_test_pattern_generator.sv =====
// Gradient test pattern generator. Each item is one pixel coordinate; the
// block answers with that pixel's blue/green/red levels for the configured
// pattern (column ramp, row ramp, diagonal radial ramp, column-row plane or
// two-channel column ramp) and flags coordinates outside the image. It is a
// fully pipelined datapath: one item enters every clock unless the output
// stalls, and then the whole pipe holds. An item passes 3 front stages for
// squares and the 65025 scaling, 16 divider stages for the diagonal
// quotient, 8 square root stages, then the output register; the linear
// ramps run their 8-step dividers alongside. A one-item skid buffer at the
// input keeps in_ready_o registered. The user must write registers over the
// cfg port only while no item is in flight; the block does not enforce it.
// After a write the diagonal denominator settles via square and sum registers.
// Depends on gtpg_pkg, gtpg_cfg, gtpg_div_step, gtpg_sqrt_step.
`default_nettype none

module gradient_test_pattern_generator (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  // configuration writes
  input  wire logic                          cfg_valid_i,
  output logic                               cfg_ready_o,
  input  wire logic [gtpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire logic [gtpg_pkg::CfgDataW-1:0] cfg_data_i,
  // coordinate items in
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire gtpg_pkg::pix_in_t             in_data_i,
  // pixel items out
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output gtpg_pkg::pix_out_t                 out_data_o
);
  import gtpg_pkg::*;

  cfg_t cfg;

  assign cfg_ready_o = 1'b1;

  gtpg_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // ---------------------------------------------------------------- flow
  logic     en;          // whole pipe advances
  logic     skid_vld_q;
  pix_in_t  skid_q;
  logic     in_acc, ent_vld;
  pix_in_t  ent;

  assign en         = !out_valid_o || out_ready_i;
  assign in_ready_o = !skid_vld_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign ent_vld    = skid_vld_q || in_acc;
  assign ent        = skid_vld_q ? skid_q : in_data_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skid_vld_q <= 1'b0;
    end else if (en) begin
      skid_vld_q <= 1'b0;
    end else if (in_acc) begin
      skid_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!en && in_acc) begin
      skid_q <= in_data_i;
    end
  end

  // valid and range flag travel with the data
  logic [PipeStg-1:0] vld_q;
  logic [PipeStg-1:0] err_q;
  logic               ent_err;

  assign ent_err = ({1'b0, ent.pixel_row} >= cfg.rows) ||
                   ({1'b0, ent.pixel_col} >= cfg.cols);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[PipeStg-2:0], ent_vld};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      err_q <= {err_q[PipeStg-2:0], ent_err};
    end
  end

  // --------------------------------------------------------- front stages
  logic [2*CoordW-1:0]  rr_q, cc_q;
  logic [SqSumW-1:0]    sum_q;
  logic [DiagNumW-1:0]  num_q;
  logic [RampNumW-1:0]  cn_q [FrontStg];
  logic [RampNumW-1:0]  rn_q [FrontStg];

  always_ff @(posedge clk_i) begin
    if (en) begin
      rr_q     <= (2*CoordW)'(ent.pixel_row) * (2*CoordW)'(ent.pixel_row);
      cc_q     <= (2*CoordW)'(ent.pixel_col) * (2*CoordW)'(ent.pixel_col);
      cn_q[0]  <= RampNumW'(FullScale) * RampNumW'(ent.pixel_col);
      rn_q[0]  <= RampNumW'(FullScale) * RampNumW'(ent.pixel_row);
      sum_q    <= SqSumW'(rr_q) + SqSumW'(cc_q);
      cn_q[1]  <= cn_q[0];
      rn_q[1]  <= rn_q[0];
      num_q    <= DiagNumW'(FullScaleSq) * DiagNumW'(sum_q);
      cn_q[2]  <= cn_q[1];
      rn_q[2]  <= rn_q[1];
    end
  end

  // --------------------------------------------------- diagonal divider
  logic [DiagNumW-1:0] drem [DiagQW+1];
  logic [DiagQW-1:0]   dq   [DiagQW+1];

  assign drem[0] = num_q;
  assign dq[0]   = '0;

  for (genvar k = 0; k < DiagQW; k++) begin : g_ddiv
    gtpg_div_step #(
      .NW  (DiagNumW),
      .DW  (DenW),
      .QW  (DiagQW),
      .BIT (DiagQW - 1 - k)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (drem[k]),
      .den_i (cfg.den),
      .q_i   (dq[k]),
      .rem_o (drem[k+1]),
      .q_o   (dq[k+1])
    );
  end

  // --------------------------------------------------------- square root
  logic [15:0] sv   [SqrtBits+1];
  logic [7:0]  sres [SqrtBits+1];
  logic [15:0] ssq  [SqrtBits+1];

  assign sv[0]   = dq[DiagQW];
  assign sres[0] = '0;
  assign ssq[0]  = '0;

  for (genvar k = 0; k < SqrtBits; k++) begin : g_sqrt
    gtpg_sqrt_step #(
      .BIT (SqrtBits - 1 - k)
    ) u_step (
      .clk_i (clk_i),
      .en_i  (en),
      .v_i   (sv[k]),
      .res_i (sres[k]),
      .sq_i  (ssq[k]),
      .v_o   (sv[k+1]),
      .res_o (sres[k+1]),
      .sq_o  (ssq[k+1])
    );
  end

  // ------------------------------------------------ linear ramp dividers
  logic [RampNumW-1:0] crem [RampQW+1];
  logic [RampNumW-1:0] rrem [RampQW+1];
  logic [RampQW-1:0]   cq   [RampQW+1];
  logic [RampQW-1:0]   rq   [RampQW+1];

  assign crem[0] = cn_q[FrontStg-1];
  assign rrem[0] = rn_q[FrontStg-1];
  assign cq[0]   = '0;
  assign rq[0]   = '0;

  for (genvar k = 0; k < RampQW; k++) begin : g_rdiv
    gtpg_div_step #(
      .NW  (RampNumW),
      .DW  (DimW),
      .QW  (RampQW),
      .BIT (RampQW - 1 - k)
    ) u_col (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (crem[k]),
      .den_i (cfg.cols),
      .q_i   (cq[k]),
      .rem_o (crem[k+1]),
      .q_o   (cq[k+1])
    );
    gtpg_div_step #(
      .NW  (RampNumW),
      .DW  (DimW),
      .QW  (RampQW),
      .BIT (RampQW - 1 - k)
    ) u_row (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rrem[k]),
      .den_i (cfg.rows),
      .q_i   (rq[k]),
      .rem_o (rrem[k+1]),
      .q_o   (rq[k+1])
    );
  end

  // ramps wait for the diagonal path
  logic [RampQW-1:0] cdl_q [RampDly];
  logic [RampQW-1:0] rdl_q [RampDly];

  always_ff @(posedge clk_i) begin
    if (en) begin
      cdl_q[0] <= cq[RampQW];
      rdl_q[0] <= rq[RampQW];
      for (int i = 1; i < RampDly; i++) begin
        cdl_q[i] <= cdl_q[i-1];
        rdl_q[i] <= rdl_q[i-1];
      end
    end
  end

  // ------------------------------------------------ channel assembly
  logic [7:0] col_r, row_r, diag_r, ramp;
  logic [7:0] ch_b, ch_g, ch_r;
  logic       single;
  pix_out_t   pix_d;

  assign col_r  = cdl_q[RampDly-1];
  assign row_r  = rdl_q[RampDly-1];
  assign diag_r = cfg.den_zero ? 8'd0 : sres[SqrtBits];

  always_comb begin
    ramp   = '0;
    single = 1'b0;
    ch_b   = '0;
    ch_g   = '0;
    ch_r   = '0;
    case (pattern_e'(cfg.pattern))
      PatColRamp: begin
        ramp   = col_r;
        single = 1'b1;
      end
      PatRowRamp: begin
        ramp   = row_r;
        single = 1'b1;
      end
      PatDiag: begin
        ramp   = diag_r;
        single = 1'b1;
      end
      PatColRowPlane, PatTwoColRamp: begin
        // held channel gets the fixed level; lower other = column ramp,
        // higher other = row ramp (plane) or column ramp (two-channel)
        case (chan_sel_e'(cfg.channel_select))
          SelBlue: begin
            ch_b = cfg.fixed_value;
            ch_g = col_r;
            ch_r = (cfg.pattern == 3'(PatColRowPlane)) ? row_r : col_r;
          end
          SelGreen: begin
            ch_g = cfg.fixed_value;
            ch_b = col_r;
            ch_r = (cfg.pattern == 3'(PatColRowPlane)) ? row_r : col_r;
          end
          SelRed: begin
            ch_r = cfg.fixed_value;
            ch_b = col_r;
            ch_g = (cfg.pattern == 3'(PatColRowPlane)) ? row_r : col_r;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    if (single) begin
      case (chan_sel_e'(cfg.channel_select))
        SelBlue:  ch_b = ramp;
        SelGreen: ch_g = ramp;
        SelRed:   ch_r = ramp;
        default: begin
          ch_b = ramp;
          ch_g = ramp;
          ch_r = ramp;
        end
      endcase
    end
  end

  always_comb begin
    pix_d.coord_error = err_q[PipeStg-1];
    pix_d.blue_out    = err_q[PipeStg-1] ? 8'd0 : ch_b;
    pix_d.green_out   = err_q[PipeStg-1] ? 8'd0 : ch_g;
    pix_d.red_out     = err_q[PipeStg-1] ? 8'd0 : ch_r;
  end

  // --------------------------------------------------- output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (en) begin
      out_valid_o <= vld_q[PipeStg-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_data_o <= pix_d;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/gtpg_checker.sv =====
// Port-level checks for the gradient test pattern generator, bound to the top.
// Depends on gtpg_pkg.
`default_nettype none

module gtpg_checker (
  input wire logic                          clk_i,
  input wire logic                          rst_ni,
  input wire logic                          cfg_valid_i,
  input wire logic                          cfg_ready_o,
  input wire logic [gtpg_pkg::CfgIdxW-1:0]  cfg_index_i,
  input wire logic [gtpg_pkg::CfgDataW-1:0] cfg_data_i,
  input wire logic                          in_valid_i,
  input wire logic                          in_ready_o,
  input wire gtpg_pkg::pix_in_t             in_data_i,
  input wire logic                          out_valid_o,
  input wire logic                          out_ready_i,
  input wire gtpg_pkg::pix_out_t            out_data_o
);
  import gtpg_pkg::*;

  logic [5:0] inflight_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_q + 6'(in_acc) - 6'(out_acc);
    end
  end

  // a held result stays put
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("result dropped or changed while stalled");

  // no result without an item behind it
  a_no_invent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> inflight_q != 6'd0)
    else $error("result with no pending item");

  // out-of-range pixels are black
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.coord_error |->
      out_data_o.blue_out == 8'd0 && out_data_o.green_out == 8'd0 &&
      out_data_o.red_out == 8'd0)
    else $error("flagged pixel carries a level");

  // input backpressure only comes from a stalled output
  a_ready_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && $past(out_valid_o && !out_ready_i))
    else $error("input stalled without output stall");

  // configuration port never stalls
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("config write refused");

endmodule

bind gradient_test_pattern_generator gtpg_checker u_gtpg_checker (.*);

`default_nettype wire
